[sv/qipt_pkg.sv]
// shared types and constants for the quad ir pan/tilt tracker
package qipt_pkg;

	localparam int unsigned NUM_SENSORS = 4;
	localparam int unsigned SAMPLE_W    = 10;
	localparam int unsigned LEVEL_W     = 11;
	localparam int unsigned ANGLE_W     = 8;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 11;

	// sensor positions in the hit vector
	localparam int unsigned SENS_UL = 0;
	localparam int unsigned SENS_UR = 1;
	localparam int unsigned SENS_LL = 2;
	localparam int unsigned SENS_LR = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAL_0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_3     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_REST  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_REST = 3'd6;

	// reset values
	localparam logic [LEVEL_W-1:0] CAL_RESET       = 11'd1025;
	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 11'd300;
	localparam logic [ANGLE_W-1:0] REST_RESET      = 8'd90;

	// angle limits and step sizes in degrees
	localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;
	localparam logic [ANGLE_W-1:0] SWEEP_STEP = 8'd5;
	localparam logic [ANGLE_W-1:0] TRACK_STEP = 8'd2;

	typedef logic [SAMPLE_W-1:0]    sample_t;
	typedef logic [LEVEL_W-1:0]     level_t;
	typedef logic [ANGLE_W-1:0]     angle_t;
	typedef logic [NUM_SENSORS-1:0] hit_vec_t;

	// what the lanes hand to the tracking stage
	typedef struct packed {
		logic     zone;
		hit_vec_t hits;
	} lane_res_t;

endpackage

[sv/qipt_if.sv]
// valid/ready channels for samples in and servo commands out
interface qipt_in_if;
	logic                  valid;
	logic                  ready;
	logic                  slow_zone;
	qipt_pkg::sample_t     sample_ul;
	qipt_pkg::sample_t     sample_ur;
	qipt_pkg::sample_t     sample_ll;
	qipt_pkg::sample_t     sample_lr;

	modport source (output valid, output slow_zone, output sample_ul, output sample_ur,
		output sample_ll, output sample_lr, input ready);
	modport sink (input valid, input slow_zone, input sample_ul, input sample_ur,
		input sample_ll, input sample_lr, output ready);
endinterface

interface qipt_out_if;
	logic              valid;
	logic              ready;
	qipt_pkg::angle_t  pan_angle;
	qipt_pkg::angle_t  tilt_angle;
	logic              tracking;
	logic              laser_on;

	modport source (output valid, output pan_angle, output tilt_angle, output tracking,
		output laser_on, input ready);
	modport sink (input valid, input pan_angle, input tilt_angle, input tracking,
		input laser_on, output ready);
endinterface

[sv/quad_ir_pan_tilt_tracker.sv]
// top level: input transfer -> stage 1 hit registers -> stage 2 result registers
// throughput one item per cycle; a stall on the result side holds both stages
// stage 1 is four parallel hit lanes, stage 2 merges them and steps the servo state
// arst_n clears both stages and sets pan/tilt to 90 degrees, sweep upward,
// baselines to 1025, threshold to 300 and both rest angles to 90
module quad_ir_pan_tilt_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qipt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [qipt_pkg::CFG_DATA_W-1:0] cfg_data,
	qipt_in_if.sink                        sample_ch,
	qipt_out_if.source                     result_ch
);
	import qipt_pkg::*;

	level_t     cal_q [NUM_SENSORS];
	level_t     thr_q;
	angle_t     pan_rest_q;
	angle_t     tilt_rest_q;

	logic       valid_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       adv_s1;
	logic       in_xfer;
	logic       zone_s1;
	hit_vec_t   hits_s1;
	sample_t    samples [NUM_SENSORS];
	lane_res_t  lanes;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SENSORS; k++) begin
				cal_q[k] <= CAL_RESET;
			end
			thr_q       <= THRESHOLD_RESET;
			pan_rest_q  <= REST_RESET;
			tilt_rest_q <= REST_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CAL_0:     cal_q[0]    <= cfg_data;
				REG_CAL_1:     cal_q[1]    <= cfg_data;
				REG_CAL_2:     cal_q[2]    <= cfg_data;
				REG_CAL_3:     cal_q[3]    <= cfg_data;
				REG_THRESHOLD: thr_q       <= cfg_data;
				REG_PAN_REST:  pan_rest_q  <= cfg_data[ANGLE_W-1:0];
				REG_TILT_REST: tilt_rest_q <= cfg_data[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign out_free        = !out_valid_q || result_ch.ready;
	assign adv_s1          = valid_s1 && out_free;
	assign sample_ch.ready = !valid_s1 || out_free;
	assign in_xfer         = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_ch.ready) begin
				valid_s1 <= sample_ch.valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			zone_s1 <= sample_ch.slow_zone;
		end
	end

	// hit lanes, one per sensor
	assign samples[SENS_UL] = sample_ch.sample_ul;
	assign samples[SENS_UR] = sample_ch.sample_ur;
	assign samples[SENS_LL] = sample_ch.sample_ll;
	assign samples[SENS_LR] = sample_ch.sample_lr;

	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
		qipt_lane u_lane (
			.clk       (clk),
			.en        (in_xfer),
			.cal_level (cal_q[g]),
			.threshold (thr_q),
			.sample    (samples[g]),
			.hit_s1    (hits_s1[g])
		);
	end

	assign lanes.zone = zone_s1;
	assign lanes.hits = hits_s1;

	// merge and state update; its registers are the result payload
	qipt_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv_s1),
		.lanes      (lanes),
		.pan_rest   (pan_rest_q),
		.tilt_rest  (tilt_rest_q),
		.pan_angle  (result_ch.pan_angle),
		.tilt_angle (result_ch.tilt_angle),
		.tracking   (result_ch.tracking),
		.laser_on   (result_ch.laser_on)
	);

	assign result_ch.valid = out_valid_q;

endmodule

[sv/qipt_lane.sv]
// one sensor lane: registered hit detection against baseline and threshold
module qipt_lane (
	input  logic              clk,
	input  logic              en,
	input  qipt_pkg::level_t  cal_level,
	input  qipt_pkg::level_t  threshold,
	input  qipt_pkg::sample_t sample,
	output logic              hit_s1
);
	import qipt_pkg::*;

	logic [LEVEL_W:0] need;
	logic             hit;

	// cal - sample > threshold  <=>  cal > sample + threshold
	always_comb begin
		need = {2'b00, sample} + {1'b0, threshold};
		hit  = {1'b0, cal_level} > need;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= hit;
		end
	end

endmodule

[sv/qipt_track.sv]
// merging stage: combines lane hits and steps the pan/tilt state, or loads the clamped rest angles outside the zone
module qipt_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  qipt_pkg::lane_res_t lanes,
	input  qipt_pkg::angle_t    pan_rest,
	input  qipt_pkg::angle_t    tilt_rest,
	output qipt_pkg::angle_t    pan_angle,
	output qipt_pkg::angle_t    tilt_angle,
	output logic                tracking,
	output logic                laser_on
);
	import qipt_pkg::*;

	angle_t     pan_q;
	angle_t     tilt_q;
	logic       sweep_up_q;
	logic       tracking_q;
	logic       laser_q;

	logic [1:0] cnt_right, cnt_left, cnt_up, cnt_down;
	logic       any_hit;
	angle_t     pan_d, tilt_d;
	logic       sweep_up_d, tracking_d, laser_d;

	// quadrant weight sums as counts on each side
	always_comb begin
		cnt_right = {1'b0, lanes.hits[SENS_UR]} + {1'b0, lanes.hits[SENS_LR]};
		cnt_left  = {1'b0, lanes.hits[SENS_UL]} + {1'b0, lanes.hits[SENS_LL]};
		cnt_up    = {1'b0, lanes.hits[SENS_UL]} + {1'b0, lanes.hits[SENS_UR]};
		cnt_down  = {1'b0, lanes.hits[SENS_LL]} + {1'b0, lanes.hits[SENS_LR]};
		any_hit   = |lanes.hits;
	end

	// next state
	always_comb begin
		pan_d      = pan_q;
		tilt_d     = tilt_q;
		sweep_up_d = sweep_up_q;
		tracking_d = 1'b0;
		laser_d    = 1'b0;
		if (!lanes.zone) begin
			pan_d  = (pan_rest > ANGLE_MAX) ? ANGLE_MAX : pan_rest;
			tilt_d = (tilt_rest > ANGLE_MAX) ? ANGLE_MAX : tilt_rest;
		end else if (any_hit) begin
			tracking_d = 1'b1;
			if (cnt_right == cnt_left && cnt_up == cnt_down) begin
				laser_d = 1'b1;
			end else begin
				// pan step
				if (cnt_right > cnt_left) begin
					pan_d = (pan_q >= ANGLE_MAX - TRACK_STEP) ? ANGLE_MAX : pan_q + TRACK_STEP;
				end else if (cnt_right < cnt_left) begin
					pan_d = (pan_q <= TRACK_STEP) ? '0 : pan_q - TRACK_STEP;
				end
				// tilt step
				if (cnt_up > cnt_down) begin
					tilt_d = (tilt_q >= ANGLE_MAX - TRACK_STEP) ? ANGLE_MAX : tilt_q + TRACK_STEP;
				end else if (cnt_up < cnt_down) begin
					tilt_d = (tilt_q <= TRACK_STEP) ? '0 : tilt_q - TRACK_STEP;
				end
			end
		end else begin
			// sweep with bounce at both ends
			if (sweep_up_q) begin
				if (pan_q >= ANGLE_MAX - SWEEP_STEP) begin
					pan_d      = ANGLE_MAX;
					sweep_up_d = 1'b0;
				end else begin
					pan_d = pan_q + SWEEP_STEP;
				end
			end else begin
				if (pan_q <= SWEEP_STEP) begin
					pan_d      = '0;
					sweep_up_d = 1'b1;
				end else begin
					pan_d = pan_q - SWEEP_STEP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q      <= REST_RESET;
			tilt_q     <= REST_RESET;
			sweep_up_q <= 1'b1;
			tracking_q <= 1'b0;
			laser_q    <= 1'b0;
		end else if (en) begin
			pan_q      <= pan_d;
			tilt_q     <= tilt_d;
			sweep_up_q <= sweep_up_d;
			tracking_q <= tracking_d;
			laser_q    <= laser_d;
		end
	end

	assign pan_angle  = pan_q;
	assign tilt_angle = tilt_q;
	assign tracking   = tracking_q;
	assign laser_on   = laser_q;

endmodule
